>>> design/bhr_pkg.sv
// ----------------------------------------------------------------------------
// bhr_pkg
// Shared types and constants for the beam hypothesis recombination block.
// ----------------------------------------------------------------------------
package bhr_pkg;

	localparam int TAG_BITS        = 16;
	localparam int SCORE_BITS      = 32;
	localparam int LEN_BITS        = 2;
	localparam int FIELD_WORD_BITS = 20;
	localparam int SLOT_BITS       = 4;

	localparam int DEF_BEAM_CAPACITY = 16;
	localparam int DEF_NGRAM_ORDER   = 3;
	localparam int DEF_WORD_ID_BITS  = 20;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_KEEP    = 2'd2,
		ACT_FULL    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Candidate as broadcast to every cell during a scan.
	typedef struct packed {
		logic [LEN_BITS-1:0]        blen;
		logic [FIELD_WORD_BITS-1:0] fw0;
		logic [FIELD_WORD_BITS-1:0] fw1;
		logic [FIELD_WORD_BITS-1:0] lw0;
		logic [FIELD_WORD_BITS-1:0] lw1;
		logic signed [SCORE_BITS-1:0] score;
		logic [TAG_BITS-1:0]        tag;
	} cand_t;

	// Token handed from cell to cell along the chain.
	typedef struct packed {
		logic                 active;
		logic                 found;
		action_t              action;
		logic [SLOT_BITS-1:0] slot;
		logic [TAG_BITS-1:0]  old_tag;
	} tok_t;

endpackage

>>> design/bhr_if.sv
// ----------------------------------------------------------------------------
// bhr_if
// Valid/ready channels for candidates in and recombination results out.
// ----------------------------------------------------------------------------
interface bhr_in_if;
	import bhr_pkg::*;

	logic valid;
	logic ready;
	logic [TAG_BITS-1:0]          cand_tag;
	logic signed [SCORE_BITS-1:0] cand_score;
	logic [LEN_BITS-1:0]          length_capped;
	logic [FIELD_WORD_BITS-1:0]   first_word_0;
	logic [FIELD_WORD_BITS-1:0]   first_word_1;
	logic [FIELD_WORD_BITS-1:0]   last_word_0;
	logic [FIELD_WORD_BITS-1:0]   last_word_1;

	modport source (
		output valid, cand_tag, cand_score, length_capped,
		output first_word_0, first_word_1, last_word_0, last_word_1,
		input  ready
	);
	modport sink (
		input  valid, cand_tag, cand_score, length_capped,
		input  first_word_0, first_word_1, last_word_0, last_word_1,
		output ready
	);
endinterface

interface bhr_out_if;
	import bhr_pkg::*;

	logic valid;
	logic ready;
	action_t               action;
	logic [SLOT_BITS-1:0]  slot;
	logic [TAG_BITS-1:0]   old_tag;

	modport source (output valid, action, slot, old_tag, input ready);
	modport sink   (input  valid, action, slot, old_tag, output ready);
endinterface

>>> design/beam_hypothesis_recombine.sv
// ----------------------------------------------------------------------------
// beam_hypothesis_recombine
// Beam of hypotheses with recombination on capped length and boundary words.
// ----------------------------------------------------------------------------
// Usage:
// Candidates arrive on the cand channel and one result per candidate leaves
// on the res channel; both use valid/ready and a transfer happens when both
// are high at a rising edge of clk.
// The beam is a row of BEAM_CAPACITY cells, one entry each. After a candidate
// transfer, a token walks the row one cell per cycle; the first valid cell
// whose bound length and boundary words match decides the outcome and, if
// the candidate scores strictly higher, is overwritten on the spot. When the
// token leaves the last cell the block either keeps that outcome or appends
// the candidate at the next free cell, or reports the beam as full.
// A candidate is thus in flight from its transfer until the token has walked
// the whole cell row and the outcome is loaded; only then can a new candidate
// be taken. The result is registered, and a new candidate is taken while an
// earlier result still waits for the receiver. If the receiver stalls, the
// finished scan holds until the result register frees.
// Reset (arst_n low) empties the beam: all cells invalid, entry count zero.
// ----------------------------------------------------------------------------
module beam_hypothesis_recombine #(
	parameter int BEAM_CAPACITY = bhr_pkg::DEF_BEAM_CAPACITY,
	parameter int NGRAM_ORDER   = bhr_pkg::DEF_NGRAM_ORDER,
	parameter int WORD_ID_BITS  = bhr_pkg::DEF_WORD_ID_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	bhr_in_if.sink     cand,
	bhr_out_if.source  res
);
	import bhr_pkg::*;

	localparam int CW = $clog2(BEAM_CAPACITY + 1);
	localparam logic [LEN_BITS-1:0] LEN_CAP = LEN_BITS'(NGRAM_ORDER - 1);

	state_t state_q, state_d;

	cand_t  cand_q;
	logic   start_q;
	tok_t   pend_q;
	logic [CW-1:0] count_q;

	tok_t   tok [BEAM_CAPACITY+1];
	logic   app_we [BEAM_CAPACITY];

	logic   accept;
	logic   load;
	logic   full;
	logic   append_fire;

	logic                 res_valid_q;
	action_t              res_action_q;
	logic [SLOT_BITS-1:0] res_slot_q;
	logic [TAG_BITS-1:0]  res_tag_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (cand.valid) state_d = ST_SCAN;
			ST_SCAN:   if (tok[BEAM_CAPACITY].active) state_d = ST_FINISH;
			ST_FINISH: if (!res_valid_q || res.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Controls derived from state.
	always_comb begin
		cand.ready = 1'b0;
		load       = 1'b0;
		case (state_q)
			ST_IDLE:   cand.ready = 1'b1;
			ST_FINISH: load = !res_valid_q || res.ready;
			default: begin
				cand.ready = 1'b0;
				load       = 1'b0;
			end
		endcase
	end

	assign accept      = cand.valid && cand.ready;
	assign full        = count_q >= CW'(BEAM_CAPACITY);
	assign append_fire = load && !pend_q.found && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept;
			if (append_fire) count_q <= count_q + 1'b1;
			if (load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	// Candidate capture; the length is bound to the model's context here.
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q.blen  <= (cand.length_capped < LEN_CAP) ? cand.length_capped : LEN_CAP;
			cand_q.fw0   <= cand.first_word_0;
			cand_q.fw1   <= cand.first_word_1;
			cand_q.lw0   <= cand.last_word_0;
			cand_q.lw1   <= cand.last_word_1;
			cand_q.score <= cand.cand_score;
			cand_q.tag   <= cand.cand_tag;
		end
		if (state_q == ST_SCAN && tok[BEAM_CAPACITY].active) begin
			pend_q <= tok[BEAM_CAPACITY];
		end
		if (load) begin
			if (pend_q.found) begin
				res_action_q <= pend_q.action;
				res_slot_q   <= pend_q.slot;
				res_tag_q    <= pend_q.old_tag;
			end else if (full) begin
				res_action_q <= ACT_FULL;
				res_slot_q   <= '0;
				res_tag_q    <= '0;
			end else begin
				res_action_q <= ACT_APPEND;
				res_slot_q   <= SLOT_BITS'(count_q);
				res_tag_q    <= '0;
			end
		end
	end

	// The token enters the first cell the cycle after the transfer.
	always_comb begin
		tok[0]        = '0;
		tok[0].active = start_q;
		tok[0].action = ACT_APPEND;
	end

	for (genvar i = 0; i < BEAM_CAPACITY; i++) begin : g_cell
		assign app_we[i] = append_fire && (count_q == CW'(i));

		bhr_cell #(
			.IDX          (i),
			.WORD_ID_BITS (WORD_ID_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cand   (cand_q),
			.tok_i  (tok[i]),
			.app_we (app_we[i]),
			.tok_o  (tok[i+1])
		);
	end

	assign res.valid   = res_valid_q;
	assign res.action  = res_action_q;
	assign res.slot    = res_slot_q;
	assign res.old_tag = res_tag_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BEAM_CAPACITY))
		else $error("entry count beyond beam capacity");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[BEAM_CAPACITY].active |-> state_q == ST_SCAN)
		else $error("token left the row outside a scan");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SCAN && start_q)
		else $error("transfer did not start a scan");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		append_fire |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance entry count");
`endif

endmodule

>>> design/bhr_cell.sv
// ----------------------------------------------------------------------------
// bhr_cell
// One beam entry. Checks the passing token against its stored hypothesis,
// replaces itself when the candidate wins or is appended here, and forwards the token.
// ----------------------------------------------------------------------------
module bhr_cell #(
	parameter int IDX          = 0,
	parameter int WORD_ID_BITS = bhr_pkg::DEF_WORD_ID_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bhr_pkg::cand_t cand,
	input  bhr_pkg::tok_t  tok_i,
	input  logic           app_we,
	output bhr_pkg::tok_t  tok_o
);
	import bhr_pkg::*;

	localparam int SW = (WORD_ID_BITS < FIELD_WORD_BITS) ? WORD_ID_BITS : FIELD_WORD_BITS;

	logic                   valid_q;
	logic [LEN_BITS-1:0]    len_q;
	logic [SW-1:0]          fw0_q, fw1_q, lw0_q, lw1_q;
	logic signed [SCORE_BITS-1:0] score_q;
	logic [TAG_BITS-1:0]    tag_q;

	logic  match;
	logic  hit;
	logic  better;
	logic  we;
	tok_t  tok_d;

	always_comb begin
		match = valid_q && (len_q == cand.blen);
		if (cand.blen != '0) begin
			match = match && (fw0_q == cand.fw0[SW-1:0]) && (lw0_q == cand.lw0[SW-1:0]);
		end
		if (cand.blen[1]) begin
			match = match && (fw1_q == cand.fw1[SW-1:0]) && (lw1_q == cand.lw1[SW-1:0]);
		end
		hit    = tok_i.active && !tok_i.found && match;
		better = cand.score > score_q;
		we     = app_we || (hit && better);

		tok_d = tok_i;
		if (hit) begin
			tok_d.found   = 1'b1;
			tok_d.action  = better ? ACT_REPLACE : ACT_KEEP;
			tok_d.slot    = SLOT_BITS'(IDX);
			tok_d.old_tag = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_o   <= '0;
		end else begin
			if (we) valid_q <= 1'b1;
			tok_o <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			len_q   <= cand.blen;
			fw0_q   <= cand.fw0[SW-1:0];
			fw1_q   <= cand.fw1[SW-1:0];
			lw0_q   <= cand.lw0[SW-1:0];
			lw1_q   <= cand.lw1[SW-1:0];
			score_q <= cand.score;
			tag_q   <= cand.tag;
		end
	end

endmodule

>>> bench/tb_beam_hypothesis_recombine.sv
// ----------------------------------------------------------------------------
// tb_beam_hypothesis_recombine
// Self-checking bench for the beam recombination block. A predictor inside a
// small scoreboard class mirrors the beam contents and works out the outcome
// of every candidate when its transfer happens. Each result transfer is
// checked field by field against the oldest outcome still awaited. The
// stimulus first walks through the corner cases on an empty beam and fills
// it. After that it sends a random mix: mostly candidates that recombine
// with a stored entry, and the rest fresh keys that meet a full beam. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_beam_hypothesis_recombine;
	timeunit 1ns;
	timeprecision 1ps;
	import bhr_pkg::*;

	localparam int SLOTS             = DEF_BEAM_CAPACITY;
	localparam int CONTEXT_WORDS     = DEF_NGRAM_ORDER - 1;
	// A scan walks the whole cell row, then decides the outcome and writes it back.
	localparam int SCAN_CYCLES       = DEF_BEAM_CAPACITY + 3;
	localparam int DRAIN_CYCLES      = 2 * SCAN_CYCLES;
	localparam int RANDOM_CANDIDATES = 700;
	localparam int LONG_HOLD_CYCLES  = 400;
	localparam int LONG_HOLD_AFTER   = 150;

	localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
	localparam logic [FIELD_WORD_BITS-1:0]   WORD_ONES = '1;

	// One candidate hypothesis as it is offered on the input channel.
	typedef struct {
		logic [TAG_BITS-1:0]          tag;
		logic signed [SCORE_BITS-1:0] score;
		logic [LEN_BITS-1:0]          length;
		logic [FIELD_WORD_BITS-1:0]   fw0;
		logic [FIELD_WORD_BITS-1:0]   fw1;
		logic [FIELD_WORD_BITS-1:0]   lw0;
		logic [FIELD_WORD_BITS-1:0]   lw1;
	} hypothesis_t;

	// One recombination outcome as it leaves on the result channel.
	typedef struct {
		action_t              action;
		logic [SLOT_BITS-1:0] slot;
		logic [TAG_BITS-1:0]  old_tag;
	} outcome_t;

	// The scoreboard keeps its own copy of the beam. Candidates are applied to
	// it in transfer order, which is the order the block handles them, so the
	// queue of awaited outcomes lines up one to one with the result transfers.
	class beam_scoreboard;
		logic                         held       [SLOTS];
		logic [LEN_BITS-1:0]          held_len   [SLOTS];
		logic [FIELD_WORD_BITS-1:0]   held_fw0   [SLOTS];
		logic [FIELD_WORD_BITS-1:0]   held_fw1   [SLOTS];
		logic [FIELD_WORD_BITS-1:0]   held_lw0   [SLOTS];
		logic [FIELD_WORD_BITS-1:0]   held_lw1   [SLOTS];
		logic signed [SCORE_BITS-1:0] held_score [SLOTS];
		logic [TAG_BITS-1:0]          held_tag   [SLOTS];
		int                           held_count;
		outcome_t                     awaited_outcomes[$];
		int                           mismatches;
		int                           outcomes_checked;
		int                           by_action[4];

		function new();
			foreach (held[i]) begin
				held[i] = 1'b0;
			end
			foreach (by_action[a]) begin
				by_action[a] = 0;
			end
			held_count       = 0;
			mismatches       = 0;
			outcomes_checked = 0;
		endfunction

		// Only the first "bound length" words of each side take part.
		function bit same_key(int i, hypothesis_t h, int blen);
			if (held_len[i] != blen)
				return 1'b0;
			if (blen >= 1 && (held_fw0[i] != h.fw0 || held_lw0[i] != h.lw0))
				return 1'b0;
			if (blen >= 2 && (held_fw1[i] != h.fw1 || held_lw1[i] != h.lw1))
				return 1'b0;
			return 1'b1;
		endfunction

		function void store_entry(int i, hypothesis_t h, int blen);
			held[i]       = 1'b1;
			held_len[i]   = LEN_BITS'(blen);
			held_fw0[i]   = h.fw0;
			held_fw1[i]   = h.fw1;
			held_lw0[i]   = h.lw0;
			held_lw1[i]   = h.lw1;
			held_score[i] = h.score;
			held_tag[i]   = h.tag;
		endfunction

		function void note_candidate(hypothesis_t h);
			outcome_t o;
			int       blen;
			bit       matched;
			blen      = (h.length > CONTEXT_WORDS) ? CONTEXT_WORDS : int'(h.length);
			matched   = 1'b0;
			o.action  = ACT_FULL;
			o.slot    = '0;
			o.old_tag = '0;
			// The first matching entry in slot order decides; ties are dropped.
			for (int i = 0; i < SLOTS; i++) begin
				if (!matched && held[i] && same_key(i, h, blen)) begin
					matched   = 1'b1;
					o.slot    = SLOT_BITS'(i);
					o.old_tag = held_tag[i];
					if (h.score <= held_score[i]) begin
						o.action = ACT_KEEP;
					end else begin
						o.action = ACT_REPLACE;
						store_entry(i, h, blen);
					end
				end
			end
			if (!matched && held_count < SLOTS) begin
				o.action = ACT_APPEND;
				o.slot   = SLOT_BITS'(held_count);
				store_entry(held_count, h, blen);
				held_count++;
			end
			awaited_outcomes = {awaited_outcomes, o};
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_outcome(outcome_t got);
			outcome_t want;
			if (awaited_outcomes.size() == 0) begin
				report($sformatf("result (action %0d slot %0d) with no candidate pending",
					got.action, got.slot));
				return;
			end
			want = awaited_outcomes.pop_front();
			outcomes_checked++;
			by_action[want.action]++;
			if (got.action !== want.action)
				report($sformatf("result %0d: action %0d, predicted %0d",
					outcomes_checked, got.action, want.action));
			if (got.slot !== want.slot)
				report($sformatf("result %0d: slot %0d, predicted %0d",
					outcomes_checked, got.slot, want.slot));
			if (got.old_tag !== want.old_tag)
				report($sformatf("result %0d: old_tag %h, predicted %h",
					outcomes_checked, got.old_tag, want.old_tag));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bhr_in_if  cand_ch ();
	bhr_out_if res_ch ();

	beam_scoreboard sb = new();
	int candidates_sent = 0;

	beam_hypothesis_recombine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch),
		.res    (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then a long pause.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic hypothesis_t make_hypothesis(
		logic [TAG_BITS-1:0] tag, logic signed [SCORE_BITS-1:0] score,
		logic [LEN_BITS-1:0] length,
		logic [FIELD_WORD_BITS-1:0] fw0, logic [FIELD_WORD_BITS-1:0] fw1,
		logic [FIELD_WORD_BITS-1:0] lw0, logic [FIELD_WORD_BITS-1:0] lw1);
		hypothesis_t h;
		h.tag    = tag;
		h.score  = score;
		h.length = length;
		h.fw0    = fw0;
		h.fw1    = fw1;
		h.lw0    = lw0;
		h.lw1    = lw1;
		return h;
	endfunction

	// A candidate with every field random; on a full beam it nearly always
	// finds no partner and is refused, unless it has length zero.
	function automatic hypothesis_t fresh_hypothesis();
		hypothesis_t h;
		h.tag    = TAG_BITS'($urandom);
		h.score  = SCORE_BITS'($urandom);
		h.length = LEN_BITS'($urandom_range(0, 3));
		h.fw0    = FIELD_WORD_BITS'($urandom);
		h.fw1    = FIELD_WORD_BITS'($urandom);
		h.lw0    = FIELD_WORD_BITS'($urandom);
		h.lw1    = FIELD_WORD_BITS'($urandom);
		return h;
	endfunction

	// A candidate that shares its key with a stored entry. Words outside the
	// bound length stay random, and the score is often placed right at the
	// stored score or one step off it, so that ties and narrow wins show up.
	function automatic hypothesis_t rematch_hypothesis();
		hypothesis_t                  h;
		int                           i;
		int                           pick;
		logic signed [SCORE_BITS-1:0] s;
		h = fresh_hypothesis();
		i = $urandom_range(0, sb.held_count - 1);
		s = sb.held_score[i];
		h.length = sb.held_len[i];
		if (sb.held_len[i] >= 1) begin
			h.fw0 = sb.held_fw0[i];
			h.lw0 = sb.held_lw0[i];
		end
		if (sb.held_len[i] >= 2) begin
			h.fw1    = sb.held_fw1[i];
			h.lw1    = sb.held_lw1[i];
			// A length of three is capped to the same bound length.
			h.length = LEN_BITS'($urandom_range(2, 3));
		end
		pick = $urandom_range(0, 9);
		if (pick >= 3 && pick <= 4)
			h.score = s;
		else if (pick >= 5 && pick <= 6)
			h.score = (s == SCORE_MAX) ? s : s + 1;
		else if (pick >= 7 && pick <= 8)
			h.score = (s == SCORE_MIN) ? s : s - 1;
		else if (pick == 9)
			h.score = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
		return h;
	endfunction

	// Offer one candidate and return at the edge where it transfers. Valid is
	// left high afterwards; it only drops if the next candidate waits first,
	// so back-to-back offers never lower and raise valid in the same step.
	task automatic send_candidate(hypothesis_t h, bit hurry);
		int gap;
		gap = hurry ? 0 : idle_span();
		if (gap > 0) begin
			cand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand_ch.valid         <= 1'b1;
		cand_ch.cand_tag      <= h.tag;
		cand_ch.cand_score    <= h.score;
		cand_ch.length_capped <= h.length;
		cand_ch.first_word_0  <= h.fw0;
		cand_ch.first_word_1  <= h.fw1;
		cand_ch.last_word_0   <= h.lw0;
		cand_ch.last_word_1   <= h.lw1;
		@(posedge clk);
		while (!cand_ch.ready)
			@(posedge clk);
		sb.note_candidate(h);
		candidates_sent++;
	endtask

	// Stimulus and end of run.
	initial begin
		hypothesis_t h;
		bit          hurry;
		arst_n                 = 1'b0;
		cand_ch.valid         <= 1'b0;
		cand_ch.cand_tag      <= '0;
		cand_ch.cand_score    <= '0;
		cand_ch.length_capped <= '0;
		cand_ch.first_word_0  <= '0;
		cand_ch.first_word_1  <= '0;
		cand_ch.last_word_0   <= '0;
		cand_ch.last_word_1   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length zero: every such candidate matches the first one stored, so
		// an equal score is dropped and a higher one replaces it.
		send_candidate(make_hypothesis(16'h0000, 32'sd0, 2'd0, '0, '0, '0, '0), 1'b0);
		send_candidate(make_hypothesis(16'hFFFF, 32'sd0, 2'd0,
			WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES), 1'b0);
		send_candidate(make_hypothesis(16'h1234, 32'sd1, 2'd0,
			20'h12345, '0, 20'h6789A, '0), 1'b0);

		// Length one compares only the outer words; a tie at the top score drops.
		send_candidate(make_hypothesis(16'hFFFF, SCORE_MAX, 2'd1,
			WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES), 1'b0);
		send_candidate(make_hypothesis(16'h0001, SCORE_MAX, 2'd1,
			WORD_ONES, '0, WORD_ONES, '0), 1'b0);

		// Length two from the bottom score upward; length three caps to two.
		send_candidate(make_hypothesis(16'h0002, SCORE_MIN, 2'd2, '0, '0, '0, '0), 1'b0);
		send_candidate(make_hypothesis(16'h0003, SCORE_MIN + 1, 2'd2, '0, '0, '0, '0), 1'b0);
		send_candidate(make_hypothesis(16'h0004, SCORE_MIN + 2, 2'd3, '0, '0, '0, '0), 1'b0);

		// Keys that differ only in an inner word are distinct at length two.
		send_candidate(make_hypothesis(16'h8000, -32'sd1, 2'd2,
			WORD_ONES, '0, WORD_ONES, WORD_ONES), 1'b0);
		send_candidate(make_hypothesis(16'h7FFF, -32'sd1, 2'd2,
			WORD_ONES, '0, WORD_ONES, '0), 1'b0);
		send_candidate(make_hypothesis(16'h5555, -32'sd65536, 2'd1,
			20'h55555, 20'h0F0F0, 20'hAAAAA, 20'hF0F0F), 1'b0);
		send_candidate(make_hypothesis(16'hAAAA, 32'sd65536, 2'd1,
			20'h55555, 20'hF0F0F, 20'hAAAAA, 20'h0F0F0), 1'b0);

		// Fill the rest of the beam with fresh keys, then hit it when full.
		while (sb.held_count < SLOTS) begin
			h        = fresh_hypothesis();
			h.length = 2'd2;
			send_candidate(h, 1'b0);
		end
		h        = fresh_hypothesis();
		h.length = 2'd3;
		send_candidate(h, 1'b0);
		send_candidate(rematch_hypothesis(), 1'b0);

		// Random part. Every fourth block of 64 candidates is sent without
		// gaps on the input side.
		for (int n = 0; n < RANDOM_CANDIDATES; n++) begin
			hurry = ((n / 64) % 4) == 3;
			if ($urandom_range(0, 3) == 0)
				h = fresh_hypothesis();
			else
				h = rematch_hypothesis();
			send_candidate(h, hurry);
		end
		cand_ch.valid <= 1'b0;

		while (sb.awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d candidates on a %0d-slot beam: %0d appended, %0d replaced,",
			candidates_sent, SLOTS, sb.by_action[ACT_APPEND], sb.by_action[ACT_REPLACE]);
		$display("%0d dropped as not better, %0d refused on a full beam; one %0d-cycle hold-off.",
			sb.by_action[ACT_KEEP], sb.by_action[ACT_FULL], LONG_HOLD_CYCLES);
		if (sb.mismatches == 0) begin
			$display("beam_hypothesis_recombine regression: pass");
		end else begin
			$display("beam_hypothesis_recombine regression: fail");
		end
		$finish;
	end

	// Result side. Each transfer is checked, then ready is chosen for the
	// next edge. Ready drops in random stalls, except in quiet phases. Once
	// enough results have come, it stays low for a long stretch. The block
	// then has a finished result waiting and a scan held behind it, so it
	// must stop taking candidates while the input side keeps offering.
	initial begin
		outcome_t got;
		int       ready_wait;
		int       phase_left;
		bit       quiet;
		bit       long_hold_done;
		logic     next_ready;
		ready_wait     = 0;
		phase_left     = 0;
		quiet          = 1'b0;
		long_hold_done = 1'b0;
		res_ch.ready  <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.action  = res_ch.action;
				got.slot    = res_ch.slot;
				got.old_tag = res_ch.old_tag;
				sb.check_outcome(got);
			end
			if (phase_left == 0) begin
				phase_left = 256;
				quiet      = ($urandom_range(0, 3) == 0);
			end
			phase_left--;
			if (!long_hold_done && sb.outcomes_checked >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				ready_wait     = LONG_HOLD_CYCLES;
			end else if (ready_wait == 0 && !quiet && $urandom_range(0, 4) == 0) begin
				ready_wait = idle_span() + 1;
			end
			next_ready = 1'b1;
			if (ready_wait > 0) begin
				ready_wait--;
				next_ready = 1'b0;
			end
			res_ch.ready <= next_ready;
		end
	end

	// Timeout. The slowest correct run, with every candidate waiting out the
	// longest input gap, the scan and the longest result stall, stays well
	// under a millisecond.
	initial begin
		#5_000_000;
		$display("beam_hypothesis_recombine regression: fail");
		$finish;
	end

endmodule

>>> files.f
design/bhr_pkg.sv
design/bhr_if.sv
design/bhr_cell.sv
design/beam_hypothesis_recombine.sv
bench/tb_beam_hypothesis_recombine.sv
